FILE: sv/assert_macros.svh
// assertion macros shared by the frame rate counter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SWFR_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// same-cycle implication
`define SWFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/swfr_pkg.sv
// shared constants and types of the sliding window frame rate counter
package swfr_pkg;

   localparam int WINDOW_FRAMES = 16;

   localparam int TICK_W   = 32;
   localparam int RATE_W   = 24;
   localparam int FILL_W   = 9;
   localparam int SUM_W    = 40;
   localparam int SCALE_Q8 = 256000;

   localparam int NUM_W  = $clog2(SCALE_Q8 * WINDOW_FRAMES + 1);
   localparam int SLOT_W = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
   localparam int CNT_W  = $clog2(NUM_W + 1);
   localparam int QX_W   = (NUM_W > RATE_W) ? NUM_W : RATE_W;

   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   typedef struct packed {
      logic start;
   } swfr_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } swfr_div_sts_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_START  = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } swfr_state_type;

endpackage

FILE: sv/swfr_req_if.sv
// frame event channel carrying the millisecond tick stamp
interface swfr_req_if import swfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] tick_ms;

   modport source (output valid, output tick_ms, input ready);
   modport sink (input valid, input tick_ms, output ready);
endinterface

FILE: sv/swfr_rsp_if.sv
// frame rate result channel
interface swfr_rsp_if import swfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rate_q8;
   logic              saturated;
   logic [FILL_W-1:0] frames_in_window;

   modport source (output valid, output rate_q8, output saturated, output frames_in_window,
                   input ready);
   modport sink (input valid, input rate_q8, input saturated, input frames_in_window,
                 output ready);
endinterface

FILE: sv/swfr_ram.sv
// generic single write port ram with registered read
module swfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/swfr_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module swfr_divider import swfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  swfr_div_ctl_type ctl,
   input  logic [NUM_W-1:0] numerator,
   input  logic [SUM_W-1:0] divisor,
   output swfr_div_sts_type sts,
   output logic [NUM_W-1:0] quotient
);

`include "assert_macros.svh"

   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] div_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [SUM_W:0]   trial;
   logic [SUM_W:0]   diff;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= '0;
         div_ff <= divisor;
         num_ff <= numerator;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

   `SWFR_ASSERT_IMPL(a_done_idle, clock, reset, done_ff, !busy_ff, "divider done while busy")
   `SWFR_ASSERT_NEXT(a_start_busy, clock, reset, ctl.start, busy_ff, "divider did not start")

endmodule

FILE: sv/sliding_window_frame_rate_top.sv
// sliding window frame rate counter top level
//
// req_chan carries one frame event per transfer with its free-running
// millisecond tick stamp. rsp_chan returns one result per event: the
// average frame rate over the last WINDOW_FRAMES intervals in unsigned
// Q16.8, a saturation flag and the number of intervals averaged.
// A request transfer passes through the read, update and start states
// to the bit-serial divider, which produces one quotient bit per cycle,
// and on to the output register. One event is in work at a time, so
// a new request is taken only once the previous one has left ST_FINISH.
// A finished result sits in an output register; the next event is taken
// while it waits. When the receiver stalls, the following result waits in
// the divider until the output register is free.
// Reset is synchronous and active high; it clears the previous tick, the
// window sum, fill count and ring slot. The interval ring needs no clear:
// an entry is only read back once every entry has been written.
module sliding_window_frame_rate_top import swfr_pkg::*; (
   input logic       clock,
   input logic       reset,
   swfr_req_if.sink   req_chan,
   swfr_rsp_if.source rsp_chan
);

`include "assert_macros.svh"

   swfr_state_type    state_ff, state_in;
   logic [TICK_W-1:0] tick_ff;
   logic [TICK_W-1:0] prev_ff;
   logic [TICK_W-1:0] interval;
   logic [SLOT_W-1:0] slot_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [TICK_W-1:0] ring_rd;
   logic              full;
   logic              ring_wr;
   logic [NUM_W-1:0]  numerator;
   logic [NUM_W-1:0]  quotient;
   logic [QX_W-1:0]   quo_ext;
   logic              clamp;
   logic              out_free;
   logic              load_rsp;
   logic              req_xfer;
   logic              finish_wait;
   swfr_div_ctl_type  div_ctl;
   swfr_div_sts_type  div_sts;

   logic              rsp_valid_ff;
   logic [RATE_W-1:0] rsp_rate_ff;
   logic              rsp_sat_ff;
   logic [FILL_W-1:0] rsp_fill_ff;

   assign interval  = tick_ff - prev_ff;
   assign full      = (fill_ff == FILL_W'(WINDOW_FRAMES));
   assign ring_wr   = (state_ff == ST_UPDATE);
   assign numerator = NUM_W'(fill_ff) * NUM_W'(SCALE_Q8);
   assign quo_ext   = QX_W'(quotient);
   assign clamp     = (sum_ff == '0) || (quo_ext > QX_W'(RATE_MAX));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign load_rsp  = (state_ff == ST_FINISH) && out_free;
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign finish_wait = (state_ff == ST_FINISH) && !out_free;
   assign div_ctl.start = (state_ff == ST_START);

   swfr_ram #(
      .WIDTH (TICK_W),
      .DEPTH (WINDOW_FRAMES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (slot_ff),
      .wr_data (interval),
      .rd_addr (slot_ff),
      .rd_data (ring_rd)
   );

   swfr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .numerator (numerator),
      .divisor   (sum_ff),
      .sts       (div_sts),
      .quotient  (quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_START;
         ST_START:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPDATE) begin
            prev_ff <= tick_ff;
            sum_ff  <= sum_ff - (full ? SUM_W'(ring_rd) : '0) + SUM_W'(interval);
            if (!full) begin
               fill_ff <= fill_ff + 1'b1;
            end
            if (slot_ff == SLOT_W'(WINDOW_FRAMES - 1)) begin
               slot_ff <= '0;
            end else begin
               slot_ff <= slot_ff + 1'b1;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         tick_ff <= req_chan.tick_ms;
      end
      if (load_rsp) begin
         rsp_rate_ff <= clamp ? RATE_MAX : quo_ext[RATE_W-1:0];
         rsp_sat_ff  <= clamp;
         rsp_fill_ff <= fill_ff;
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.rate_q8          = rsp_rate_ff;
   assign rsp_chan.saturated        = rsp_sat_ff;
   assign rsp_chan.frames_in_window = rsp_fill_ff;

   `SWFR_ASSERT_RST(a_fill_bound, clock, reset, fill_ff <= FILL_W'(WINDOW_FRAMES), "fill high")
   `SWFR_ASSERT_NEXT(a_accept_read, clock, reset, req_xfer, state_ff == ST_READ, "no ring read")
   `SWFR_ASSERT_IMPL(a_rsp_frames, clock, reset, rsp_valid_ff, rsp_fill_ff != '0, "empty window")
   `SWFR_ASSERT_NEXT(a_finish_hold, clock, reset, finish_wait, state_ff == ST_FINISH, "result lost")

endmodule
